// ===== rtl/core/bot_pkg.sv =====
// ----------------------------------------------------------------------------
// bot_pkg: shared constants for the box overlap test core
// Default widths and the register map of the configuration port.
// ----------------------------------------------------------------------------
package bot_pkg;

  // Default coordinate width and threshold fraction width.
  localparam int COORD_BITS_DEFAULT = 12;
  localparam int FRAC_BITS_DEFAULT  = 16;

  // APB data width and the address width that covers both registers.
  localparam int APB_DATA_W = 32;
  localparam int CFG_ADDR_W = 3;

  // Register indexes, one word apart.
  typedef enum logic [0:0] {
    REG_MATCH_FRACTION = 1'b0,
    REG_IOU_FRACTION   = 1'b1
  } reg_index_t;

endpackage

// ===== rtl/core/bot_cfg.sv =====
// ----------------------------------------------------------------------------
// bot_cfg: threshold registers
// APB-style register file holding the match and IoU thresholds.
// ----------------------------------------------------------------------------
module bot_cfg
  import bot_pkg::*;
#(
  parameter int FRAC_BITS = FRAC_BITS_DEFAULT
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [CFG_ADDR_W-1:0] paddr,
  input  logic [APB_DATA_W-1:0] pwdata,
  output logic [APB_DATA_W-1:0] prdata,
  output logic                  pready,
  output logic [FRAC_BITS:0]    match_fraction,
  output logic [FRAC_BITS:0]    iou_fraction
);

  localparam int TW = FRAC_BITS + 1;
  // Reset thresholds: 0.8 rounded to nearest, and exactly one half.
  localparam int MATCH_RESET = ((8 << FRAC_BITS) + 5) / 10;
  localparam int IOU_RESET   = 1 << (FRAC_BITS - 1);

  reg_index_t index;
  logic       write_en;

  assign pready   = 1'b1;
  assign index    = reg_index_t'(paddr[CFG_ADDR_W-1:2]);
  assign write_en = psel & penable & pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      match_fraction <= TW'(MATCH_RESET);
      iou_fraction   <= TW'(IOU_RESET);
    end else if (write_en) begin
      case (index)
        REG_MATCH_FRACTION: match_fraction <= pwdata[TW-1:0];
        REG_IOU_FRACTION:   iou_fraction   <= pwdata[TW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (index)
      REG_MATCH_FRACTION: prdata = APB_DATA_W'(match_fraction);
      REG_IOU_FRACTION:   prdata = APB_DATA_W'(iou_fraction);
      default:            prdata = '0;
    endcase
  end

endmodule

// ===== rtl/core/bot_geom.sv =====
// ----------------------------------------------------------------------------
// bot_geom: intersection extents and box areas
// Two pipeline stages: edge selection, then overlap sizes and box areas.
// ----------------------------------------------------------------------------
module bot_geom
  import bot_pkg::*;
#(
  parameter int COORD_BITS = COORD_BITS_DEFAULT
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    in_valid,
  output logic                    in_ready,
  input  logic [COORD_BITS-1:0]   first_top,
  input  logic [COORD_BITS-1:0]   first_left,
  input  logic [COORD_BITS-1:0]   first_width,
  input  logic [COORD_BITS-1:0]   first_height,
  input  logic [COORD_BITS-1:0]   second_top,
  input  logic [COORD_BITS-1:0]   second_left,
  input  logic [COORD_BITS-1:0]   second_width,
  input  logic [COORD_BITS-1:0]   second_height,
  output logic                    out_valid,
  input  logic                    out_ready,
  output logic [COORD_BITS-1:0]   inter_width,
  output logic [COORD_BITS-1:0]   inter_height,
  output logic [2*COORD_BITS-1:0] first_area,
  output logic [2*COORD_BITS-1:0] second_area
);

  localparam int CW = COORD_BITS;
  localparam int EW = COORD_BITS + 1;
  localparam int AW = 2 * COORD_BITS;

  // Stage 1: near edges are the larger starts, far edges the smaller ends.
  logic          s1_valid;
  logic          s1_ready;
  logic [CW-1:0] s1_lo_x;
  logic [CW-1:0] s1_lo_y;
  logic [EW-1:0] s1_hi_x;
  logic [EW-1:0] s1_hi_y;
  logic [CW-1:0] s1_w1;
  logic [CW-1:0] s1_h1;
  logic [CW-1:0] s1_w2;
  logic [CW-1:0] s1_h2;

  logic [EW-1:0] right1;
  logic [EW-1:0] right2;
  logic [EW-1:0] bottom1;
  logic [EW-1:0] bottom2;

  // Stage 2 results go straight to the outputs.
  logic          s2_valid;
  logic          s2_ready;
  logic [EW-1:0] span_x;
  logic [EW-1:0] span_y;

  assign right1  = EW'(first_left) + EW'(first_width);
  assign right2  = EW'(second_left) + EW'(second_width);
  assign bottom1 = EW'(first_top) + EW'(first_height);
  assign bottom2 = EW'(second_top) + EW'(second_height);

  assign s2_ready = !s2_valid || out_ready;
  assign s1_ready = !s1_valid || s2_ready;
  assign in_ready = s1_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (s1_ready) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_ready && in_valid) begin
      s1_lo_x <= (first_left > second_left) ? first_left : second_left;
      s1_lo_y <= (first_top > second_top) ? first_top : second_top;
      s1_hi_x <= (right1 < right2) ? right1 : right2;
      s1_hi_y <= (bottom1 < bottom2) ? bottom1 : bottom2;
      s1_w1   <= first_width;
      s1_h1   <= first_height;
      s1_w2   <= second_width;
      s1_h2   <= second_height;
    end
  end

  // The overlap never exceeds either width, so it fits the coordinate width.
  assign span_x = (s1_hi_x >= EW'(s1_lo_x)) ? s1_hi_x - EW'(s1_lo_x) : '0;
  assign span_y = (s1_hi_y >= EW'(s1_lo_y)) ? s1_hi_y - EW'(s1_lo_y) : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else if (s2_ready) begin
      s2_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s2_ready && s1_valid) begin
      inter_width  <= span_x[CW-1:0];
      inter_height <= span_y[CW-1:0];
      first_area   <= AW'(s1_w1) * AW'(s1_h1);
      second_area  <= AW'(s1_w2) * AW'(s1_h2);
    end
  end

  assign out_valid = s2_valid;

endmodule

// ===== rtl/core/bot_thresh.sv =====
// ----------------------------------------------------------------------------
// bot_thresh: area products and threshold decisions
// Four pipeline stages: intersection area, union and containment products,
// IoU product with containment compare, and the final IoU compare.
// ----------------------------------------------------------------------------
module bot_thresh
  import bot_pkg::*;
#(
  parameter int COORD_BITS = COORD_BITS_DEFAULT,
  parameter int FRAC_BITS  = FRAC_BITS_DEFAULT
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic [FRAC_BITS:0]      match_fraction,
  input  logic [FRAC_BITS:0]      iou_fraction,
  input  logic                    in_valid,
  output logic                    in_ready,
  input  logic [COORD_BITS-1:0]   inter_width,
  input  logic [COORD_BITS-1:0]   inter_height,
  input  logic [2*COORD_BITS-1:0] first_area,
  input  logic [2*COORD_BITS-1:0] second_area,
  output logic                    out_valid,
  input  logic                    out_ready,
  output logic                    boxes_overlap
);

  localparam int AW  = 2 * COORD_BITS;     // box area
  localparam int UW  = AW + 1;             // union area
  localparam int TW  = FRAC_BITS + 1;      // threshold
  localparam int PW  = AW + TW;            // threshold times box area
  localparam int QW  = UW + TW;            // threshold times union area
  localparam int SW  = AW + FRAC_BITS;     // scaled intersection

  // Stage 3: intersection area.
  logic          s3_valid;
  logic          s3_ready;
  logic [AW-1:0] s3_ai;
  logic [AW-1:0] s3_a1;
  logic [AW-1:0] s3_a2;

  // Stage 4: union area and containment products.
  logic          s4_valid;
  logic          s4_ready;
  logic [AW-1:0] s4_ai;
  logic [UW-1:0] s4_au;
  logic [PW-1:0] s4_p1;
  logic [PW-1:0] s4_p2;
  logic [SW-1:0] s4_scaled;

  // Stage 5: IoU product and containment verdict.
  logic          s5_valid;
  logic          s5_ready;
  logic [AW-1:0] s5_ai;
  logic [QW-1:0] s5_p3;
  logic          s5_contain;
  logic [SW-1:0] s5_scaled;

  // Stage 6: final verdict.
  logic          s6_valid;
  logic          s6_ready;

  assign s6_ready = !s6_valid || out_ready;
  assign s5_ready = !s5_valid || s6_ready;
  assign s4_ready = !s4_valid || s5_ready;
  assign s3_ready = !s3_valid || s4_ready;
  assign in_ready = s3_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      s3_valid <= 1'b0;
      s4_valid <= 1'b0;
      s5_valid <= 1'b0;
      s6_valid <= 1'b0;
    end else begin
      if (s3_ready) s3_valid <= in_valid;
      if (s4_ready) s4_valid <= s3_valid;
      if (s5_ready) s5_valid <= s4_valid;
      if (s6_ready) s6_valid <= s5_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s3_ready && in_valid) begin
      s3_ai <= AW'(inter_width) * AW'(inter_height);
      s3_a1 <= first_area;
      s3_a2 <= second_area;
    end
  end

  // The intersection lies inside both boxes, so the union never goes negative.
  always_ff @(posedge clk) begin
    if (s4_ready && s3_valid) begin
      s4_ai <= s3_ai;
      s4_au <= UW'(s3_a1) + UW'(s3_a2) - UW'(s3_ai);
      s4_p1 <= PW'(match_fraction) * PW'(s3_a1);
      s4_p2 <= PW'(match_fraction) * PW'(s3_a2);
    end
  end

  assign s4_scaled = {s4_ai, {FRAC_BITS{1'b0}}};
  assign s5_scaled = {s5_ai, {FRAC_BITS{1'b0}}};

  always_ff @(posedge clk) begin
    if (s5_ready && s4_valid) begin
      s5_ai      <= s4_ai;
      s5_p3      <= QW'(iou_fraction) * QW'(s4_au);
      s5_contain <= (PW'(s4_scaled) >= s4_p1) || (PW'(s4_scaled) >= s4_p2);
    end
  end

  always_ff @(posedge clk) begin
    if (s6_ready && s5_valid) begin
      boxes_overlap <= s5_contain || (QW'(s5_scaled) >= s5_p3);
    end
  end

  assign out_valid = s6_valid;

  // The intersection area can never exceed either box area.
  assert property (@(posedge clk) disable iff (rst)
    s3_valid |-> (s3_ai <= s3_a1) && (s3_ai <= s3_a2))
    else $error("intersection area larger than a box area");

  // The union always covers the intersection.
  assert property (@(posedge clk) disable iff (rst)
    s4_valid |-> (s4_au >= UW'(s4_ai)))
    else $error("union area smaller than intersection area");

  // An empty output stage takes the item waiting in the stage before it.
  assert property (@(posedge clk) disable iff (rst)
    (s5_valid && !s6_valid) |=> s6_valid)
    else $error("output stage failed to load a waiting item");

  // A zero intersection with nonzero areas and nonzero thresholds cannot match.
  assert property (@(posedge clk) disable iff (rst)
    (s5_valid && s6_ready && s5_ai == '0 && s5_p3 != '0 && !s5_contain)
      |=> !boxes_overlap)
    else $error("disjoint boxes reported as overlapping");

endmodule

// ===== rtl/core/box_overlap_test_core.sv =====
// ----------------------------------------------------------------------------
// box_overlap_test_core: decides whether two boxes are the same detection
// Streams box pairs in and one match flag per pair out, with the match and
// IoU thresholds held in an APB-style register file.
// ----------------------------------------------------------------------------
// Throughput: one box pair per cycle while m_tready is high; every stage
//   is a register slice with its own valid bit, so a stall only backs up
//   as far as the first bubble.
// Reset (rst, synchronous, active high): clears all stage valid bits and
//   loads the thresholds with 0.8 (match) and 0.5 (IoU). No clearing pass.
// ----------------------------------------------------------------------------
module box_overlap_test_core
  import bot_pkg::*;
#(
  parameter int COORD_BITS = COORD_BITS_DEFAULT,
  parameter int FRAC_BITS  = FRAC_BITS_DEFAULT
) (
  input  logic                  clk,
  input  logic                  rst,
  // Input stream: one pair of boxes per transaction.
  input  logic                  s_tvalid,
  output logic                  s_tready,
  // s_tdata, lowest bits first: first_top, first_left, first_width,
  // first_height, second_top, second_left, second_width, second_height.
  input  logic [((8*COORD_BITS+7)/8)*8-1:0] s_tdata,
  // Output stream: one match flag per pair.
  output logic                  m_tvalid,
  input  logic                  m_tready,
  // m_tdata, lowest bit first: boxes_overlap, then zero padding.
  output logic [7:0]            m_tdata,
  // Configuration port.
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [CFG_ADDR_W-1:0] paddr,
  input  logic [APB_DATA_W-1:0] pwdata,
  output logic [APB_DATA_W-1:0] prdata,
  output logic                  pready
);

  localparam int CW = COORD_BITS;
  localparam int AW = 2 * COORD_BITS;

  // Thresholds from the register file, read directly by every stage. Change
  // them only while the pipeline is empty; the block does not enforce it.
  logic [FRAC_BITS:0] match_fraction;
  logic [FRAC_BITS:0] iou_fraction;

  // Handshake and data between the geometry and threshold sections.
  logic          geom_valid;
  logic          geom_ready;
  logic [CW-1:0] inter_width;
  logic [CW-1:0] inter_height;
  logic [AW-1:0] first_area;
  logic [AW-1:0] second_area;
  logic          boxes_overlap;

  bot_cfg #(
    .FRAC_BITS(FRAC_BITS)
  ) u_cfg (
    .clk            (clk),
    .rst            (rst),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .prdata         (prdata),
    .pready         (pready),
    .match_fraction (match_fraction),
    .iou_fraction   (iou_fraction)
  );

  // The first two stages work out how far the boxes overlap in each
  // direction and the area of each box.
  bot_geom #(
    .COORD_BITS(COORD_BITS)
  ) u_geom (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (s_tvalid),
    .in_ready      (s_tready),
    .first_top     (s_tdata[0*CW +: CW]),
    .first_left    (s_tdata[1*CW +: CW]),
    .first_width   (s_tdata[2*CW +: CW]),
    .first_height  (s_tdata[3*CW +: CW]),
    .second_top    (s_tdata[4*CW +: CW]),
    .second_left   (s_tdata[5*CW +: CW]),
    .second_width  (s_tdata[6*CW +: CW]),
    .second_height (s_tdata[7*CW +: CW]),
    .out_valid     (geom_valid),
    .out_ready     (geom_ready),
    .inter_width   (inter_width),
    .inter_height  (inter_height),
    .first_area    (first_area),
    .second_area   (second_area)
  );

  // The remaining four stages form the intersection and union areas and
  // compare the scaled intersection exactly against threshold times area.
  // The last of them is the output register.
  bot_thresh #(
    .COORD_BITS(COORD_BITS),
    .FRAC_BITS (FRAC_BITS)
  ) u_thresh (
    .clk            (clk),
    .rst            (rst),
    .match_fraction (match_fraction),
    .iou_fraction   (iou_fraction),
    .in_valid       (geom_valid),
    .in_ready       (geom_ready),
    .inter_width    (inter_width),
    .inter_height   (inter_height),
    .first_area     (first_area),
    .second_area    (second_area),
    .out_valid      (m_tvalid),
    .out_ready      (m_tready),
    .boxes_overlap  (boxes_overlap)
  );

  assign m_tdata = {7'b0, boxes_overlap};

endmodule
